### hw/rtl/queued_sample_playback_stepper_assert.svh
// Assertion helpers for the top-level file that checks this block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef QUEUED_SAMPLE_PLAYBACK_STEPPER_ASSERT_SVH
`define QUEUED_SAMPLE_PLAYBACK_STEPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QSP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qsp same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qsp next-cycle check failed");

`endif

### hw/rtl/qsp_pkg.sv
package qsp_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int ENTRY_W     = 4;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 24;
  localparam int STEP_W      = 24;
  localparam int IDX_W       = 25;
  localparam int ACC_W       = STEP_W + 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_ENTRY = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  length;
    logic [STEP_W-1:0] step;
  } desc_t;

  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] addr;
    desc_t              desc;
  } tbl_wr_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] queue_count;
    logic               playing;
    logic               sample_valid;
    logic               fetch_new;
    logic [ADDR_W-1:0]  read_address;
    logic [ENTRY_W-1:0] entry_playing;
  } result_t;

endpackage

### hw/rtl/qsp_table.sv
module qsp_table (
  input  logic                          clk,
  input  qsp_pkg::tbl_wr_t              wr,
  input  logic [qsp_pkg::ENTRY_W-1:0]   rd_addr_a,
  input  logic [qsp_pkg::ENTRY_W-1:0]   rd_addr_b,
  output qsp_pkg::desc_t                rd_data_a,
  output qsp_pkg::desc_t                rd_data_b
);
  import qsp_pkg::*;

  desc_t mem [QUEUE_DEPTH];
  desc_t rd_a_r;
  desc_t rd_b_r;

  // A write to the address being read is forwarded, so the read data always
  // reflects every transaction accepted so far.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.desc;
    end
    if (wr.en && (wr.addr == rd_addr_a)) begin
      rd_a_r <= wr.desc;
    end else begin
      rd_a_r <= mem[rd_addr_a];
    end
    if (wr.en && (wr.addr == rd_addr_b)) begin
      rd_b_r <= wr.desc;
    end else begin
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

### hw/rtl/qsp_ctrl.sv
module qsp_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [1:0]                    op,
  input  logic [qsp_pkg::ADDR_W-1:0]    entry_base,
  input  logic [qsp_pkg::LEN_W-1:0]     entry_length,
  input  logic [qsp_pkg::STEP_W-1:0]    entry_step,
  input  logic [qsp_pkg::ENTRY_W-1:0]   start_entry,
  input  qsp_pkg::desc_t                cur_desc,
  input  qsp_pkg::desc_t                nxt_desc,
  output qsp_pkg::tbl_wr_t              tbl_wr,
  output logic [qsp_pkg::ENTRY_W-1:0]   rd_addr_a,
  output logic [qsp_pkg::ENTRY_W-1:0]   rd_addr_b,
  output qsp_pkg::result_t              result
);
  import qsp_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [ENTRY_W-1:0] entry_r, entry_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [FRAC_BITS-1:0] phase_r, phase_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic               lastv_r, lastv_nxt;
  logic               active_r, active_nxt;

  status_t            status;
  logic               valid;
  logic               fetch;
  logic [ADDR_W-1:0]  addr;
  desc_t              desc;
  logic [IDX_W-1:0]   idx;
  logic [FRAC_BITS-1:0] ph;
  logic               lv;
  logic               have;
  logic [ACC_W-1:0]   acc;
  logic [COUNT_W-1:0] next_entry;
  logic [ENTRY_W-1:0] rd_entry;

  always_comb begin
    count_nxt  = count_r;
    entry_nxt  = entry_r;
    idx_nxt    = idx_r;
    phase_nxt  = phase_r;
    last_nxt   = last_r;
    lastv_nxt  = lastv_r;
    active_nxt = active_r;
    status     = ST_OK;
    valid      = 1'b0;
    fetch      = 1'b0;
    addr       = '0;
    tbl_wr     = '0;
    desc       = cur_desc;
    idx        = idx_r;
    ph         = phase_r;
    lv         = lastv_r;
    have       = 1'b1;
    acc        = '0;
    next_entry = COUNT_W'(entry_r) + COUNT_W'(1);

    unique case (op)
      OP_ADD: begin
        if (count_r >= COUNT_W'(QUEUE_DEPTH)) begin
          status = ST_FULL;
        end else begin
          tbl_wr.en          = accept;
          tbl_wr.addr        = count_r[ENTRY_W-1:0];
          tbl_wr.desc.base   = entry_base;
          tbl_wr.desc.length = entry_length;
          tbl_wr.desc.step   = entry_step;
          count_nxt          = count_r + COUNT_W'(1);
        end
      end
      OP_START: begin
        if (COUNT_W'(start_entry) >= count_r) begin
          status = ST_BAD_ENTRY;
        end else begin
          entry_nxt  = start_entry;
          idx_nxt    = '0;
          phase_nxt  = '0;
          last_nxt   = '0;
          lastv_nxt  = 1'b0;
          active_nxt = 1'b1;
        end
      end
      OP_TICK: begin
        if (active_r) begin
          // End of buffer: hand over to the following entry, or stop.
          if (idx >= IDX_W'(desc.length)) begin
            if (next_entry >= count_r) begin
              active_nxt = 1'b0;
              have       = 1'b0;
            end else begin
              entry_nxt = next_entry[ENTRY_W-1:0];
              desc      = nxt_desc;
              idx       = '0;
              ph        = '0;
              lv        = 1'b0;
              idx_nxt   = '0;
              phase_nxt = '0;
              last_nxt  = '0;
              lastv_nxt = 1'b0;
            end
          end
          if (have && (idx < IDX_W'(desc.length))) begin
            valid     = 1'b1;
            fetch     = !(lv && (idx == last_r));
            addr      = desc.base + ADDR_W'(idx);
            last_nxt  = idx;
            lastv_nxt = 1'b1;
            acc       = ACC_W'(ph) + ACC_W'(desc.step);
            idx_nxt   = idx + IDX_W'(acc >> FRAC_BITS);
            phase_nxt = acc[FRAC_BITS-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // The table reads always follow the entry that is current after this cycle,
  // together with the one after it.
  assign rd_entry  = accept ? entry_nxt : entry_r;
  assign rd_addr_a = rd_entry;
  assign rd_addr_b = rd_entry + ENTRY_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      entry_r  <= '0;
      idx_r    <= '0;
      phase_r  <= '0;
      last_r   <= '0;
      lastv_r  <= 1'b0;
      active_r <= 1'b0;
    end else if (accept) begin
      count_r  <= count_nxt;
      entry_r  <= entry_nxt;
      idx_r    <= idx_nxt;
      phase_r  <= phase_nxt;
      last_r   <= last_nxt;
      lastv_r  <= lastv_nxt;
      active_r <= active_nxt;
    end
  end

  always_comb begin
    result.status        = status;
    result.queue_count   = count_nxt;
    result.playing       = active_nxt;
    result.sample_valid  = valid;
    result.fetch_new     = fetch;
    result.read_address  = addr;
    result.entry_playing = entry_nxt;
  end

endmodule

### hw/rtl/queued_sample_playback_stepper.sv
// Queued fractional-step sample player. Transactions are registered:
// an add, start or tick accepted at one edge has its result in the output
// register after that edge, and a new transaction is taken in every cycle
// unless a result is waiting on out_ready. The rate is set by the single
// pass of step logic (end-of-buffer compare, address add, phase add), with
// the descriptor queue kept in a small two-port table whose registered reads
// always hold the current entry and the one after it. No clearing pass is
// needed after reset; only entries below the queue count are ever played.
`include "queued_sample_playback_stepper_assert.svh"

module queued_sample_playback_stepper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [qsp_pkg::ADDR_W-1:0]    in_entry_base,
  input  logic [qsp_pkg::LEN_W-1:0]     in_entry_length,
  input  logic [qsp_pkg::STEP_W-1:0]    in_entry_step,
  input  logic [qsp_pkg::ENTRY_W-1:0]   in_start_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [qsp_pkg::COUNT_W-1:0]   out_queue_count,
  output logic                          out_playing,
  output logic                          out_sample_valid,
  output logic                          out_fetch_new,
  output logic [qsp_pkg::ADDR_W-1:0]    out_read_address,
  output logic [qsp_pkg::ENTRY_W-1:0]   out_entry_playing
);
  import qsp_pkg::*;

  logic               accept;
  tbl_wr_t            tbl_wr;
  logic [ENTRY_W-1:0] rd_addr_a;
  logic [ENTRY_W-1:0] rd_addr_b;
  desc_t              cur_desc;
  desc_t              nxt_desc;
  result_t            result;
  result_t            out_res_r;
  logic               out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  qsp_table u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (cur_desc),
    .rd_data_b (nxt_desc)
  );

  qsp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .op           (in_op),
    .entry_base   (in_entry_base),
    .entry_length (in_entry_length),
    .entry_step   (in_entry_step),
    .start_entry  (in_start_entry),
    .cur_desc     (cur_desc),
    .nxt_desc     (nxt_desc),
    .tbl_wr       (tbl_wr),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_queue_count   = out_res_r.queue_count;
  assign out_playing       = out_res_r.playing;
  assign out_sample_valid  = out_res_r.sample_valid;
  assign out_fetch_new     = out_res_r.fetch_new;
  assign out_read_address  = out_res_r.read_address;
  assign out_entry_playing = out_res_r.entry_playing;

  `QSP_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_r)
  `QSP_ASSERT_SAME(a_sample_while_playing, out_valid_r && out_res_r.sample_valid,
                   out_res_r.playing && (out_res_r.status == ST_OK))
  `QSP_ASSERT_SAME(a_fetch_needs_sample, out_valid_r && out_res_r.fetch_new,
                   out_res_r.sample_valid)
  `QSP_ASSERT_SAME(a_count_in_range, out_valid_r,
                   out_res_r.queue_count <= COUNT_W'(QUEUE_DEPTH))

endmodule
